FILE: src/ppdq_pkg.sv
// Shared types and codes for the ping-pong drop queue.
// No dependencies; imported by the top, the controller and the testbench.
package ppdq_pkg;

   // Widths fixed by the channel fields
   localparam int DATA_W = 32;
   localparam int WIDE_W = 64;

   // Request operation codes
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   typedef enum logic [1:0] {
      WARN_NONE       = 2'd0,
      WARN_RECOVERED  = 2'd1,
      WARN_FIRST_DROP = 2'd2
   } warn_type;

   // Result flags travelling from the controller down the pipeline
   typedef struct packed {
      logic     pop_valid;
      logic     dropped;
      warn_type warn_event;
   } flags_type;

endpackage

FILE: src/ping_pong_drop_queue_top.sv
// Ping-pong drop queue: a request is registered into stage s1 and the store's
// read register, then into the output register. Throughput one item per cycle
// unless rsp_ready stalls; the single read port sets the two-stage pipeline.
// Reset clears bank select, counters, drop warning, stop flag and pipeline
// valids at once; the bank store is not cleared and needs no clearing pass.
module ping_pong_drop_queue_top #(
   parameter int BANK_DEPTH  = 256,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_func,
   input  logic [31:0]             req_entry_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_pop_valid,
   output logic [31:0]             rsp_pop_data,
   output logic                    rsp_dropped,
   output logic [1:0]              rsp_warn_event
);
   import ppdq_pkg::*;

   localparam int AW = $clog2(2 * BANK_DEPTH);

   logic                   accept;
   flags_type              ctrl_flags;
   logic                   wr_en, rd_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [ENTRY_WIDTH-1:0] wr_data, rd_data;
   logic [WIDE_W-1:0]      entry_wide, rd_wide;

   logic                   s1_valid_ff, s1_valid_in;
   flags_type              s1_flags_ff;
   logic                   out_valid_ff, out_valid_in;
   flags_type              out_flags_ff;
   logic [DATA_W-1:0]      out_data_ff;
   logic                   out_free;
   logic                   s1_adv;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   assign entry_wide = WIDE_W'(req_entry_data);
   assign wr_data    = entry_wide[ENTRY_WIDTH-1:0];
   assign rd_wide    = WIDE_W'(rd_data);

   ppdq_ctrl #(
      .BANK_DEPTH (BANK_DEPTH),
      .ADDR_WIDTH (AW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .func             (req_func),
      .flags            (ctrl_flags),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr)
   );

   ppdq_bank_ram #(
      .DEPTH      (2 * BANK_DEPTH),
      .WIDTH      (ENTRY_WIDTH),
      .ADDR_WIDTH (AW)
   ) u_bank_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign s1_valid_in  = accept || (s1_valid_ff && !out_free);
   assign out_valid_in = s1_adv || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // read data stays in the store's output register until the transfer moves on
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_flags_ff <= ctrl_flags;
      end
      if (s1_adv) begin
         out_flags_ff <= s1_flags_ff;
         out_data_ff  <= s1_flags_ff.pop_valid ? rd_wide[DATA_W-1:0] : '0;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pop_valid  = out_flags_ff.pop_valid;
   assign rsp_pop_data   = out_data_ff;
   assign rsp_dropped    = out_flags_ff.dropped;
   assign rsp_warn_event = out_flags_ff.warn_event;

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_flags_ff))
      else $error("pending read lost while the result was stalled");

   a_empty_pop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pop_valid |-> rsp_pop_data == '0)
      else $error("non-zero data without a popped entry");

   a_pop_no_warn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pop_valid |-> !rsp_dropped && rsp_warn_event == WARN_NONE)
      else $error("pop result carries push flags");

endmodule

FILE: src/ppdq_bank_ram.sv
// Two-bank entry store: one write port, one read port, registered read data.
// No package dependencies.
module ppdq_bank_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 32,
   parameter int ADDR_WIDTH = 9
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ppdq_ctrl.sv
// Queue controller: bank select, counters, drop warning and stop register.
// Depends on ppdq_pkg; drives the bank store's write and read ports.
module ppdq_ctrl #(
   parameter int BANK_DEPTH = 256,
   parameter int ADDR_WIDTH = $clog2(2 * BANK_DEPTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data,
   input  logic                    accept,
   input  logic                    func,
   output ppdq_pkg::flags_type     flags,
   output logic                    wr_en,
   output logic [ADDR_WIDTH-1:0]   wr_addr,
   output logic                    rd_en,
   output logic [ADDR_WIDTH-1:0]   rd_addr
);
   import ppdq_pkg::*;

   localparam int CW = $clog2(BANK_DEPTH + 1);
   localparam int IW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   logic          stopped_ff, stopped_in;
   logic          write_bank_sel_ff, write_bank_sel_in;
   logic [CW-1:0] write_count_ff, write_count_in;
   logic [CW-1:0] read_index_ff, read_index_in;
   logic [CW-1:0] read_count_ff, read_count_in;
   logic          full_warned_ff, full_warned_in;

   logic          has_room;
   logic          read_done;
   logic          swap;
   logic          rd_bank;
   logic [IW-1:0] wr_idx;
   logic [IW-1:0] rd_idx;

   assign has_room  = write_count_ff < CW'(BANK_DEPTH);
   assign read_done = read_index_ff >= read_count_ff;
   assign swap      = read_done && (write_count_ff != '0);
   assign wr_idx    = write_count_ff[IW-1:0];
   assign rd_idx    = swap ? '0 : read_index_ff[IW-1:0];
   // after a swap the old write bank becomes the read bank
   assign rd_bank   = swap ? write_bank_sel_ff : ~write_bank_sel_ff;

   assign wr_addr = ADDR_WIDTH'(wr_idx)
                  + (write_bank_sel_ff ? ADDR_WIDTH'(BANK_DEPTH) : '0);
   assign rd_addr = ADDR_WIDTH'(rd_idx)
                  + (rd_bank ? ADDR_WIDTH'(BANK_DEPTH) : '0);

   always_comb begin
      stopped_in        = csr_write_enable ? csr_write_data : stopped_ff;
      write_bank_sel_in = write_bank_sel_ff;
      write_count_in    = write_count_ff;
      read_index_in     = read_index_ff;
      read_count_in     = read_count_ff;
      full_warned_in    = full_warned_ff;
      flags             = '{pop_valid: 1'b0, dropped: 1'b0, warn_event: WARN_NONE};
      wr_en             = 1'b0;
      rd_en             = 1'b0;
      if (accept) begin
         case (func)
            FUNC_PUSH: begin
               if (!stopped_ff) begin
                  if (has_room) begin
                     wr_en          = 1'b1;
                     write_count_in = write_count_ff + CW'(1);
                     if (full_warned_ff) begin
                        full_warned_in   = 1'b0;
                        flags.warn_event = WARN_RECOVERED;
                     end
                  end else begin
                     flags.dropped = 1'b1;
                     if (!full_warned_ff) begin
                        full_warned_in   = 1'b1;
                        flags.warn_event = WARN_FIRST_DROP;
                     end
                  end
               end
            end
            default: begin
               if (!read_done || swap) begin
                  rd_en           = 1'b1;
                  flags.pop_valid = 1'b1;
                  if (swap) begin
                     write_bank_sel_in = ~write_bank_sel_ff;
                     read_count_in     = write_count_ff;
                     write_count_in    = '0;
                     read_index_in     = CW'(1);
                  end else begin
                     read_index_in = read_index_ff + CW'(1);
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_ff        <= 1'b0;
         write_bank_sel_ff <= 1'b0;
         write_count_ff    <= '0;
         read_index_ff     <= '0;
         read_count_ff     <= '0;
         full_warned_ff    <= 1'b0;
      end else begin
         stopped_ff        <= stopped_in;
         write_bank_sel_ff <= write_bank_sel_in;
         write_count_ff    <= write_count_in;
         read_index_ff     <= read_index_in;
         read_count_ff     <= read_count_in;
         full_warned_ff    <= full_warned_in;
      end
   end

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      read_index_ff <= read_count_ff)
      else $error("read index beyond read count");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      write_count_ff <= CW'(BANK_DEPTH))
      else $error("write count beyond bank depth");

   a_drop_needs_full: assert property (@(posedge clock) disable iff (reset)
      flags.dropped |-> !has_room && !wr_en && !rd_en)
      else $error("drop flagged while the write bank has room");

   a_swap_resets_write: assert property (@(posedge clock) disable iff (reset)
      accept && func == FUNC_POP && swap |=> write_count_ff == '0 && read_index_ff == CW'(1))
      else $error("bank swap did not restart the counters");

endmodule

FILE: tb/ppdq_checker.sv
// Checker for the ping-pong drop queue: watches the request, result and csr ports,
// keeps its own copy of both banks and counters, and compares every result.
// Depends on ppdq_pkg for the operation codes and the warning event type.
module ppdq_checker #(
   parameter int BANK_DEPTH = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic                        csr_write_data,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_func,
   input  logic [ppdq_pkg::DATA_W-1:0] req_entry_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_pop_valid,
   input  logic [ppdq_pkg::DATA_W-1:0] rsp_pop_data,
   input  logic                        rsp_dropped,
   input  logic [1:0]                  rsp_warn_event,
   output int                          fail_count,
   output int                          outstanding,
   output int                          drop_count,
   output int                          swap_count,
   output int                          empty_pop_count
);
   import ppdq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COUNT_W = $clog2(BANK_DEPTH + 1);

   typedef struct packed {
      logic              pop_valid;
      logic [DATA_W-1:0] pop_data;
      logic              dropped;
      warn_type          warn_event;
   } queue_result_type;

   logic [DATA_W-1:0]  bank_mem [0:2*BANK_DEPTH-1];
   logic               wr_bank;
   logic [COUNT_W-1:0] wr_count;
   logic [COUNT_W-1:0] rd_index;
   logic [COUNT_W-1:0] rd_count;
   logic               full_warned;
   logic               stop_flag;
   queue_result_type   pending_results [$];

   task automatic apply_request(input logic func, input logic [DATA_W-1:0] data,
                                output queue_result_type res);
      bit have;
      res = '0;
      have = 1'b1;
      if (func == FUNC_PUSH) begin
         if (!stop_flag) begin
            if (wr_count < BANK_DEPTH) begin
               bank_mem[int'(wr_bank) * BANK_DEPTH + int'(wr_count)] = data;
               wr_count = wr_count + 1'b1;
               if (full_warned) begin
                  full_warned = 1'b0;
                  res.warn_event = WARN_RECOVERED;
               end
            end else begin
               res.dropped = 1'b1;
               drop_count++;
               if (!full_warned) begin
                  full_warned = 1'b1;
                  res.warn_event = WARN_FIRST_DROP;
               end
            end
         end
      end else begin
         // read bank used up: swap roles if the write bank holds anything
         if (rd_index >= rd_count) begin
            if (wr_count == 0) begin
               have = 1'b0;
               empty_pop_count++;
            end else begin
               wr_bank  = ~wr_bank;
               rd_count = wr_count;
               rd_index = '0;
               wr_count = '0;
               swap_count++;
            end
         end
         if (have) begin
            res.pop_valid = 1'b1;
            res.pop_data  = bank_mem[(wr_bank ? 0 : BANK_DEPTH) + int'(rd_index)];
            rd_index      = rd_index + 1'b1;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                              input logic [DATA_W-1:0] want);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      queue_result_type want;
      queue_result_type next;
      if (reset) begin
         wr_bank         = 1'b0;
         wr_count        = '0;
         rd_index        = '0;
         rd_count        = '0;
         full_warned     = 1'b0;
         stop_flag       = 1'b0;
         fail_count      = 0;
         drop_count      = 0;
         swap_count      = 0;
         empty_pop_count = 0;
         pending_results.delete();
      end else begin
         if (csr_write_enable)
            stop_flag = csr_write_data;
         // retire the result first so a spurious one is never paired with this edge's request
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result transfer with nothing expected, actual %b %h %b %h",
                        $time, rsp_pop_valid, rsp_pop_data, rsp_dropped, rsp_warn_event);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("pop_valid", DATA_W'(rsp_pop_valid), DATA_W'(want.pop_valid));
               check_field("pop_data", rsp_pop_data, want.pop_data);
               check_field("dropped", DATA_W'(rsp_dropped), DATA_W'(want.dropped));
               check_field("warn_event", DATA_W'(rsp_warn_event), DATA_W'(want.warn_event));
            end
         end
         if (req_valid && req_ready) begin
            apply_request(req_func, req_entry_data, next);
            pending_results.push_back(next);
         end
      end
      outstanding = pending_results.size();
   end

endmodule

FILE: tb/tb.sv
// Top of the ping-pong drop queue testbench: clock, reset, csr writes and
// request/result stimulus with random idling. Needs ppdq_pkg, the block and ppdq_checker.
module tb;
   import ppdq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 500000;

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic              csr_write_data;
   logic              req_valid;
   logic              req_ready;
   logic              req_func;
   logic [DATA_W-1:0] req_entry_data;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_pop_valid;
   logic [DATA_W-1:0] rsp_pop_data;
   logic              rsp_dropped;
   logic [1:0]        rsp_warn_event;

   int fail_count, outstanding, drop_count, swap_count, empty_pop_count;
   int cycle_count, push_count, pop_count, stop_writes, stall_left;
   bit quiet;

   ping_pong_drop_queue_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_entry_data   (req_entry_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pop_valid    (rsp_pop_valid),
      .rsp_pop_data     (rsp_pop_data),
      .rsp_dropped      (rsp_dropped),
      .rsp_warn_event   (rsp_warn_event)
   );

   ppdq_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_entry_data   (req_entry_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pop_valid    (rsp_pop_valid),
      .rsp_pop_data     (rsp_pop_data),
      .rsp_dropped      (rsp_dropped),
      .rsp_warn_event   (rsp_warn_event),
      .fail_count       (fail_count),
      .outstanding      (outstanding),
      .drop_count       (drop_count),
      .swap_count       (swap_count),
      .empty_pop_count  (empty_pop_count)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, outstanding);
         $display("TEST FAILED");
         $finish;
      end
   end

   // mostly short idles, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (!quiet && !reset && $urandom_range(0, 99) < 25) begin
         stall_left <= idle_len() - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send(input logic func, input logic [DATA_W-1:0] data);
      int gap;
      gap = (!quiet && $urandom_range(0, 99) < 30) ? idle_len() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_entry_data <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (func == FUNC_PUSH)
         push_count++;
      else
         pop_count++;
   endtask

   // hold until every expected result has been transferred
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      stop_writes++;
   endtask

   function automatic logic [DATA_W-1:0] pick_data();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return '0;
      if (r == 1)
         return '1;
      return $urandom;
   endfunction

   task automatic run_phase(input int items, input int push_pct, input logic stop,
                            input bit calm);
      wait_idle();
      csr_write(stop);
      quiet = calm;
      repeat (items) begin
         send(($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP, pick_data());
      end
      quiet = 1'b0;
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      req_valid        = 1'b0;
      req_func         = FUNC_PUSH;
      req_entry_data   = '0;
      rsp_ready        = 1'b0;
      stall_left       = 0;
      quiet            = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pop, extreme payloads, swap while pushing, drain to empty
      csr_write(1'b0);
      send(FUNC_POP, 32'hDEAD_BEEF);
      send(FUNC_PUSH, 32'h0000_0000);
      send(FUNC_PUSH, 32'hFFFF_FFFF);
      send(FUNC_PUSH, 32'h8000_0001);
      send(FUNC_PUSH, 32'h7FFF_FFFE);
      send(FUNC_POP, 32'hFFFF_FFFF);
      send(FUNC_PUSH, 32'h1234_5678);
      send(FUNC_POP, 32'h0000_0000);
      send(FUNC_POP, 32'h0000_0000);
      send(FUNC_POP, 32'h0000_0000);
      send(FUNC_POP, 32'h0000_0000);
      send(FUNC_POP, 32'h0000_0000);
      send(FUNC_PUSH, 32'hC3C3_3C3C);

      // directed: stopped pushes leave the queue alone, pops still work
      wait_idle();
      csr_write(1'b1);
      send(FUNC_PUSH, 32'hA5A5_A5A5);
      send(FUNC_POP, 32'h0000_0000);
      send(FUNC_POP, 32'h0000_0000);
      send(FUNC_PUSH, 32'h5A5A_5A5A);
      wait_idle();
      csr_write(1'b0);
      send(FUNC_POP, 32'h0000_0000);

      // random: fill past full, drain, stopped, steady, heavy pressure, drain
      run_phase(290, 100, 1'b0, 1'b0);
      run_phase(300, 10, 1'b0, 1'b0);
      run_phase(250, 55, 1'b1, 1'b0);
      run_phase(250, 60, 1'b0, 1'b1);
      run_phase(300, 92, 1'b0, 1'b0);
      run_phase(260, 30, 1'b0, 1'b0);

      wait_idle();
      repeat (10) @(posedge clock);
      $display("Ran %0d pushes and %0d pops over %0d stop-flag writes", push_count,
               pop_count, stop_writes);
      $display("Saw %0d drops, %0d bank swaps and %0d pops on an empty queue",
               drop_count, swap_count, empty_pop_count);
      if (fail_count == 0 && outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
